// ===== sv/shallow_water_surface_step_unit_macros.svh =====
// Assertion macros shared by the shallow-water step unit.
// No dependencies; included by the top level, the only module that carries assertions.
`ifndef SHALLOW_WATER_SURFACE_STEP_UNIT_MACROS_SVH
`define SHALLOW_WATER_SURFACE_STEP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SWSS_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("swss assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SWSS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("swss assertion failed");

`endif

// ===== sv/swss_pkg.sv =====
// Shared types and constants of the shallow-water step unit.
// No dependencies; imported by the cell, the update unit and the top level.
package swss_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE_BOTTOM  = 2'd0,
    ACT_WRITE_SURFACE = 2'd1,
    ACT_RUN_STEP      = 2'd2,
    ACT_READ          = 2'd3
  } action_e;

  typedef enum logic {
    CFG_FLUX_GAIN  = 1'b0,
    CFG_ACCEL_GAIN = 1'b1
  } cfg_index_e;

  typedef enum logic {
    UPD_FLUX  = 1'b0,
    UPD_ACCEL = 1'b1
  } upd_kind_e;

  localparam logic [15:0] FLUX_GAIN_RESET  = 16'd64;
  localparam logic [15:0] ACCEL_GAIN_RESET = 16'd128;

  localparam int FLUX_SHIFT  = 20;
  localparam int ACCEL_SHIFT = 8;

  localparam logic signed [15:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [15:0] SAT_MIN = 16'sh8000;
  localparam logic [14:0] DEPTH_MAX = 15'h7fff;

  typedef struct packed {
    logic signed [15:0] surface;
    logic signed [15:0] bottom;
    logic signed [15:0] velocity;
    logic [14:0]        depth;
  } cell_t;

  typedef struct packed {
    logic surface;
    logic bottom;
    logic velocity;
    logic depth;
  } cell_wr_t;

  typedef struct packed {
    logic               valid;
    upd_kind_e          kind;
    logic signed [15:0] value;
  } upd_wb_t;

endpackage

// ===== sv/shallow_water_surface_step_unit.sv =====
// A write or read keeps busy high while it walks the ring; a read's result strobes in
// the cycle in which busy falls. A time step keeps busy high through its depth, flux and acceleration passes.
// One column passes the head of the rotating ring of cells per cycle while busy is high.
// Reset (asynchronous, active low) clears all stored heights and velocities at once and loads
// the gain registers with their defaults. Results cannot be stalled by the receiver.
// Gain writes are accepted only while no command is in progress.
`include "shallow_water_surface_step_unit_macros.svh"
module shallow_water_surface_step_unit import swss_pkg::*; #(
  parameter int COLUMNS = 256,
  parameter int BORDER  = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         action_i,
  input  logic [7:0]         column_i,
  input  logic signed [15:0] height_value_i,
  output logic               result_valid_o,
  output logic signed [15:0] surface_out_o,
  output logic signed [15:0] bottom_out_o,
  output logic signed [15:0] velocity_out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int CW        = $clog2(COLUMNS);
  localparam int CMPW      = (CW > 8) ? CW : 8;
  localparam int LOOKAHEAD = 2;
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

  localparam logic [1:0] PH_DEPTH = 2'd0;
  localparam logic [1:0] PH_FLUX  = 2'd1;
  localparam logic [1:0] PH_ACCEL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_STEP = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [CW-1:0]      col_q;
  logic [1:0]         phase_q;
  action_e            action_q;
  logic [7:0]         column_q;
  logic signed [15:0] height_q;
  logic [15:0]        flux_gain_q;
  logic [15:0]        accel_gain_q;
  logic               result_valid_q;
  logic signed [15:0] surface_out_q;
  logic signed [15:0] bottom_out_q;
  logic signed [15:0] velocity_out_q;

  cell_t              cell_s [COLUMNS];
  logic               shift_s;
  logic               accept_s;
  logic               col_last_s;
  logic               col_match_s;
  cell_wr_t           hd_wr_s;
  logic signed [15:0] hd_value_s;
  logic [14:0]        hd_depth_s;
  logic signed [16:0] depth_diff_s;

  logic [CW:0]        la_s;
  logic               la_wrap_s;
  logic [CW:0]        iss_col_s;
  logic [1:0]         iss_pass_s;
  logic               iss_valid_s;
  upd_kind_e          iss_kind_s;
  upd_wb_t            wb_s;

  assign accept_s    = start_i && (state_q == S_IDLE);
  assign shift_s     = (state_q != S_IDLE);
  assign col_last_s  = (col_q == COL_LAST);
  assign col_match_s = (CMPW'(col_q) == CMPW'(column_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = (action_e'(action_i) == ACT_RUN_STEP) ? S_STEP : S_WALK;
        end
      end
      S_WALK: begin
        if (col_last_s) begin
          state_d = S_IDLE;
        end
      end
      S_STEP: begin
        if (col_last_s && (phase_q == PH_ACCEL)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      col_q          <= '0;
      phase_q        <= PH_DEPTH;
      result_valid_q <= 1'b0;
      flux_gain_q    <= FLUX_GAIN_RESET;
      accel_gain_q   <= ACCEL_GAIN_RESET;
    end else begin
      state_q        <= state_d;
      result_valid_q <= (state_q == S_WALK) && col_last_s && (action_q == ACT_READ);
      if (shift_s) begin
        col_q <= col_last_s ? '0 : col_q + CW'(1);
        if ((state_q == S_STEP) && col_last_s) begin
          phase_q <= (phase_q == PH_ACCEL) ? PH_DEPTH : phase_q + 2'd1;
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_FLUX_GAIN:  flux_gain_q  <= cfg_data_i;
          CFG_ACCEL_GAIN: accel_gain_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_s) begin
      action_q <= action_e'(action_i);
      column_q <= column_i;
      height_q <= height_value_i;
      if (action_e'(action_i) == ACT_READ) begin
        surface_out_q  <= '0;
        bottom_out_q   <= '0;
        velocity_out_q <= '0;
      end
    end else if ((state_q == S_WALK) && col_match_s && (action_q == ACT_READ)) begin
      surface_out_q  <= cell_s[0].surface;
      bottom_out_q   <= cell_s[0].bottom;
      velocity_out_q <= cell_s[0].velocity;
    end
  end

  // Columns are issued two places ahead of the head, so that results land as they pass it.
  assign la_s       = {1'b0, col_q} + (CW + 1)'(LOOKAHEAD);
  assign la_wrap_s  = (la_s >= (CW + 1)'(COLUMNS));
  assign iss_col_s  = la_wrap_s ? la_s - (CW + 1)'(COLUMNS) : la_s;
  assign iss_pass_s = la_wrap_s ? phase_q + 2'd1 : phase_q;
  assign iss_kind_s = (iss_pass_s == PH_FLUX) ? UPD_FLUX : UPD_ACCEL;
  assign iss_valid_s = (state_q == S_STEP)
                    && ((iss_pass_s == PH_FLUX) || (iss_pass_s == PH_ACCEL))
                    && (iss_col_s >= (CW + 1)'(BORDER))
                    && (iss_col_s <= (CW + 1)'(COLUMNS - BORDER - 1));

  swss_update u_update (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .issue_i      (iss_valid_s),
    .kind_i       (iss_kind_s),
    .left_i       (cell_s[LOOKAHEAD - 1]),
    .mid_i        (cell_s[LOOKAHEAD]),
    .right_i      (cell_s[LOOKAHEAD + 1]),
    .head_i       (cell_s[0]),
    .flux_gain_i  (flux_gain_q),
    .accel_gain_i (accel_gain_q),
    .wb_o         (wb_s)
  );

  assign depth_diff_s = $signed({cell_s[0].surface[15], cell_s[0].surface})
                      - $signed({cell_s[0].bottom[15], cell_s[0].bottom});

  always_comb begin
    if (depth_diff_s < 17'sd0) begin
      hd_depth_s = '0;
    end else if (depth_diff_s > $signed({2'b00, DEPTH_MAX})) begin
      hd_depth_s = DEPTH_MAX;
    end else begin
      hd_depth_s = depth_diff_s[14:0];
    end
  end

  always_comb begin
    hd_wr_s    = '0;
    hd_value_s = height_q;
    if ((state_q == S_WALK) && col_match_s) begin
      case (action_q)
        ACT_WRITE_BOTTOM:  hd_wr_s.bottom  = 1'b1;
        ACT_WRITE_SURFACE: hd_wr_s.surface = 1'b1;
        default: ;
      endcase
    end
    if ((state_q == S_STEP) && (phase_q == PH_DEPTH)) begin
      hd_wr_s.depth = 1'b1;
    end
    if (wb_s.valid) begin
      hd_value_s = wb_s.value;
      if (wb_s.kind == UPD_FLUX) begin
        hd_wr_s.surface = 1'b1;
      end else begin
        hd_wr_s.velocity = 1'b1;
      end
    end
  end

  for (genvar k = 0; k < COLUMNS; k++) begin : g_cell
    localparam bit IS_TAIL = (k == COLUMNS - 1);
    swss_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift_s),
      .nbr_i   (cell_s[(k + 1) % COLUMNS]),
      .wr_i    (IS_TAIL ? hd_wr_s : cell_wr_t'('0)),
      .value_i (hd_value_s),
      .depth_i (hd_depth_s),
      .cell_o  (cell_s[k])
    );
  end

  assign busy_o         = (state_q != S_IDLE);
  assign cfg_ready_o    = (state_q == S_IDLE);
  assign result_valid_o = result_valid_q;
  assign surface_out_o  = surface_out_q;
  assign bottom_out_o   = bottom_out_q;
  assign velocity_out_o = velocity_out_q;

  `SWSS_ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, result_valid_q, !result_valid_q)
  `SWSS_ASSERT_IMP(a_strobe_idle, clk_i, rst_ni, result_valid_q, state_q == S_IDLE)
  `SWSS_ASSERT_IMP(a_idle_aligned, clk_i, rst_ni, state_q == S_IDLE,
                   (col_q == '0) && (phase_q == PH_DEPTH))
  `SWSS_ASSERT_IMP(a_wb_in_step, clk_i, rst_ni, wb_s.valid,
                   (state_q == S_STEP) && (phase_q != PH_DEPTH))

endmodule

// ===== sv/swss_cell.sv =====
// One column of the rotating ring: surface, bottom, velocity and depth.
// Depends on swss_pkg for the cell and write-control types.
module swss_cell import swss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  cell_t              nbr_i,
  input  cell_wr_t           wr_i,
  input  logic signed [15:0] value_i,
  input  logic [14:0]        depth_i,
  output cell_t              cell_o
);

  cell_t              nxt_s;
  logic signed [15:0] surface_q;
  logic signed [15:0] bottom_q;
  logic signed [15:0] velocity_q;
  logic [14:0]        depth_q;

  always_comb begin
    nxt_s = nbr_i;
    if (wr_i.surface) begin
      nxt_s.surface = value_i;
    end
    if (wr_i.bottom) begin
      nxt_s.bottom = value_i;
    end
    if (wr_i.velocity) begin
      nxt_s.velocity = value_i;
    end
    if (wr_i.depth) begin
      nxt_s.depth = depth_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surface_q  <= '0;
      bottom_q   <= '0;
      velocity_q <= '0;
    end else if (shift_i) begin
      surface_q  <= nxt_s.surface;
      bottom_q   <= nxt_s.bottom;
      velocity_q <= nxt_s.velocity;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      depth_q <= nxt_s.depth;
    end
  end

  always_comb begin
    cell_o.surface  = surface_q;
    cell_o.bottom   = bottom_q;
    cell_o.velocity = velocity_q;
    cell_o.depth    = depth_q;
  end

endmodule

// ===== sv/swss_update.sv =====
// Pipelined arithmetic for the surface and velocity updates of one column.
// Depends on swss_pkg; fed from the ring cells, writes back at the head.
module swss_update import swss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        issue_i,
  input  upd_kind_e   kind_i,
  input  cell_t       left_i,
  input  cell_t       mid_i,
  input  cell_t       right_i,
  input  cell_t       head_i,
  input  logic [15:0] flux_gain_i,
  input  logic [15:0] accel_gain_i,
  output upd_wb_t     wb_o
);

  localparam logic signed [50:0] RND_FLUX  = 51'sd1 <<< (FLUX_SHIFT - 1);
  localparam logic signed [50:0] RND_ACCEL = 51'sd1 <<< (ACCEL_SHIFT - 1);

  logic [15:0]        sum_l_s;
  logic [15:0]        sum_r_s;
  logic signed [16:0] slope_s;
  logic signed [32:0] p_l_s;
  logic signed [32:0] p_r_s;
  logic signed [32:0] p_a_s;

  logic               s1_valid_q;
  upd_kind_e          s1_kind_q;
  logic signed [32:0] s1_pl_q;
  logic signed [32:0] s1_pr_q;

  logic signed [33:0] diff_s;
  logic signed [50:0] mul_s;
  logic signed [50:0] neg_s;

  logic               s2_valid_q;
  upd_kind_e          s2_kind_q;
  logic signed [50:0] s2_val_q;

  logic signed [50:0] rnd_s;
  logic signed [50:0] shd_s;
  logic signed [15:0] old_s;
  logic signed [51:0] total_s;
  logic signed [15:0] sat_s;

  assign sum_l_s = {1'b0, left_i.depth} + {1'b0, mid_i.depth};
  assign sum_r_s = {1'b0, mid_i.depth} + {1'b0, right_i.depth};
  assign p_l_s   = $signed({1'b0, sum_l_s}) * left_i.velocity;
  assign p_r_s   = $signed({1'b0, sum_r_s}) * mid_i.velocity;
  assign slope_s = $signed({right_i.surface[15], right_i.surface})
                 - $signed({mid_i.surface[15], mid_i.surface});
  assign p_a_s   = slope_s * $signed({1'b0, accel_gain_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_kind_q <= kind_i;
    if (kind_i == UPD_FLUX) begin
      s1_pl_q <= p_l_s;
      s1_pr_q <= p_r_s;
    end else begin
      s1_pl_q <= p_a_s;
      s1_pr_q <= '0;
    end
  end

  assign diff_s = $signed({s1_pl_q[32], s1_pl_q}) - $signed({s1_pr_q[32], s1_pr_q});
  assign mul_s  = diff_s * $signed({1'b0, flux_gain_i});
  assign neg_s  = -$signed({{18{s1_pl_q[32]}}, s1_pl_q});

  always_ff @(posedge clk_i) begin
    s2_kind_q <= s1_kind_q;
    s2_val_q  <= (s1_kind_q == UPD_FLUX) ? mul_s : neg_s;
  end

  always_comb begin
    if (s2_kind_q == UPD_FLUX) begin
      rnd_s = s2_val_q + RND_FLUX;
      shd_s = rnd_s >>> FLUX_SHIFT;
      old_s = head_i.surface;
    end else begin
      rnd_s = s2_val_q + RND_ACCEL;
      shd_s = rnd_s >>> ACCEL_SHIFT;
      old_s = head_i.velocity;
    end
    total_s = $signed({shd_s[50], shd_s}) + $signed({{36{old_s[15]}}, old_s});
    if (total_s > $signed({{36{SAT_MAX[15]}}, SAT_MAX})) begin
      sat_s = SAT_MAX;
    end else if (total_s < $signed({{36{SAT_MIN[15]}}, SAT_MIN})) begin
      sat_s = SAT_MIN;
    end else begin
      sat_s = total_s[15:0];
    end
  end

  always_comb begin
    wb_o.valid = s2_valid_q;
    wb_o.kind  = s2_kind_q;
    wb_o.value = sat_s;
  end

endmodule

// ===== test/surface_step_checker.sv =====
// Checker for the shallow-water step unit: follows command, result and gain-write beats,
// keeps its own copy of the column stores and compares every column read field by field.
// Depends on swss_pkg for the action and register codes and the fixed-point constants.
module surface_step_checker import swss_pkg::*; #(
  parameter int COLUMNS = 256,
  parameter int BORDER  = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         action_i,
  input  logic [7:0]         column_i,
  input  logic signed [15:0] height_value_i,
  input  logic               result_valid_i,
  input  logic signed [15:0] surface_out_i,
  input  logic signed [15:0] bottom_out_i,
  input  logic signed [15:0] velocity_out_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output int                 pending_o,
  output int                 mismatches_o,
  output int                 reads_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]         column;
    logic signed [15:0] surface;
    logic signed [15:0] bottom;
    logic signed [15:0] velocity;
  } column_read_t;

  column_read_t       expected_reads [$];
  logic signed [15:0] surface_mem [COLUMNS];
  logic signed [15:0] bottom_mem [COLUMNS];
  logic signed [15:0] velocity_mem [COLUMNS];
  int                 depth_mem [COLUMNS];
  logic [15:0]        flux_gain;
  logic [15:0]        accel_gain;
  int                 mismatch_count;
  int                 read_count;

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return SAT_MAX;
    if (v < -32768) return SAT_MIN;
    return 16'(v);
  endfunction

  function automatic longint shift_round_half_up(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    column_read_t want;
    column_read_t got;
    int           d;
    longint       left;
    longint       right;
    longint       slope;
    longint       gain;
    if (!rst_ni) begin
      for (int i = 0; i < COLUMNS; i++) begin
        surface_mem[i]  = '0;
        bottom_mem[i]   = '0;
        velocity_mem[i] = '0;
        depth_mem[i]    = 0;
      end
      flux_gain      = FLUX_GAIN_RESET;
      accel_gain     = ACCEL_GAIN_RESET;
      mismatch_count = 0;
      read_count     = 0;
      expected_reads.delete();
      pending_o       <= 0;
      mismatches_o    <= 0;
      reads_checked_o <= 0;
    end else begin
      if (result_valid_i) begin
        if (expected_reads.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result beat with no read outstanding (surface %0d bottom %0d velocity %0d)",
                     $realtime, surface_out_i, bottom_out_i, velocity_out_i);
          end
        end else begin
          want = expected_reads.pop_front();
          read_count++;
          if (surface_out_i !== want.surface || bottom_out_i !== want.bottom ||
              velocity_out_i !== want.velocity) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: column %0d expected surface %0d bottom %0d velocity %0d, got %0d %0d %0d",
                       $realtime, want.column, want.surface, want.bottom, want.velocity,
                       surface_out_i, bottom_out_i, velocity_out_i);
            end
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_FLUX_GAIN:  flux_gain = cfg_data_i;
          CFG_ACCEL_GAIN: accel_gain = cfg_data_i;
          default: ;
        endcase
      end

      if (start_i && !busy_i) begin
        case (action_e'(action_i))
          ACT_WRITE_BOTTOM: begin
            if (column_i < COLUMNS) bottom_mem[column_i] = height_value_i;
          end
          ACT_WRITE_SURFACE: begin
            if (column_i < COLUMNS) surface_mem[column_i] = height_value_i;
          end
          ACT_RUN_STEP: begin
            for (int i = 0; i < COLUMNS; i++) begin
              d = int'(surface_mem[i]) - int'(bottom_mem[i]);
              if (d < 0) d = 0;
              if (d > 32767) d = 32767;
              depth_mem[i] = d;
            end
            gain = longint'(flux_gain);
            for (int i = BORDER; i < COLUMNS - BORDER; i++) begin
              left  = longint'(depth_mem[i - 1] + depth_mem[i]) * longint'(velocity_mem[i - 1]);
              right = longint'(depth_mem[i] + depth_mem[i + 1]) * longint'(velocity_mem[i]);
              surface_mem[i] = clamp16(longint'(surface_mem[i]) +
                                       shift_round_half_up((left - right) * gain, FLUX_SHIFT));
            end
            gain = longint'(accel_gain);
            for (int i = BORDER; i < COLUMNS - BORDER; i++) begin
              slope = longint'(surface_mem[i + 1]) - longint'(surface_mem[i]);
              velocity_mem[i] = clamp16(longint'(velocity_mem[i]) +
                                        shift_round_half_up(-slope * gain, ACCEL_SHIFT));
            end
          end
          ACT_READ: begin
            got.column = column_i;
            if (column_i < COLUMNS) begin
              got.surface  = surface_mem[column_i];
              got.bottom   = bottom_mem[column_i];
              got.velocity = velocity_mem[column_i];
            end else begin
              got.surface  = '0;
              got.bottom   = '0;
              got.velocity = '0;
            end
            expected_reads.push_back(got);
          end
          default: ;
        endcase
      end

      pending_o       <= expected_reads.size();
      mismatches_o    <= mismatch_count;
      reads_checked_o <= read_count;
    end
  end

endmodule

// ===== test/testbench.sv =====
// Top of the shallow-water step unit testbench: clock, reset, command and gain-write stimulus.
// Instantiates shallow_water_surface_step_unit and surface_step_checker; uses swss_pkg codes.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import swss_pkg::*;

  localparam int COLUMNS     = 256;
  localparam int BORDER      = 3;
  localparam int PHASE_ITEMS = 190;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         action_i = '0;
  logic [7:0]         column_i = '0;
  logic signed [15:0] height_value_i = '0;
  logic               result_valid_o;
  logic signed [15:0] surface_out_o;
  logic signed [15:0] bottom_out_o;
  logic signed [15:0] velocity_out_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i = 1'b0;
  logic [15:0]        cfg_data_i = '0;

  int pending;
  int mismatches;
  int reads_checked;
  int idle_pct = 0;
  int items_sent = 0;
  int steps_sent = 0;

  always #5 clk_i = ~clk_i;

  shallow_water_surface_step_unit #(
    .COLUMNS(COLUMNS),
    .BORDER (BORDER)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .action_i      (action_i),
    .column_i      (column_i),
    .height_value_i(height_value_i),
    .result_valid_o(result_valid_o),
    .surface_out_o (surface_out_o),
    .bottom_out_o  (bottom_out_o),
    .velocity_out_o(velocity_out_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  surface_step_checker #(
    .COLUMNS(COLUMNS),
    .BORDER (BORDER)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .action_i       (action_i),
    .column_i       (column_i),
    .height_value_i (height_value_i),
    .result_valid_i (result_valid_o),
    .surface_out_i  (surface_out_o),
    .bottom_out_i   (bottom_out_o),
    .velocity_out_i (velocity_out_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pending_o      (pending),
    .mismatches_o   (mismatches),
    .reads_checked_o(reads_checked)
  );

  function automatic logic [15:0] clamp_height(int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  task automatic send_item(input action_e act, input logic [7:0] col, input logic [15:0] h);
    int gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3 * COLUMNS) : $urandom_range(1, 8);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    action_i       <= act;
    column_i       <= col;
    height_value_i <= h;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
    if (act == ACT_RUN_STEP) steps_sent++;
  endtask

  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy_o) @(posedge clk_i);
    repeat (3 * COLUMNS + 8) @(posedge clk_i);
  endtask

  task automatic set_gains(input logic [15:0] flux, input logic [15:0] accel);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_FLUX_GAIN;
    cfg_data_i  <= flux;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CFG_ACCEL_GAIN;
    cfg_data_i  <= accel;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic profile_sequence();
    logic [7:0] base;
    int         len;
    int         b;
    int         s;
    base = 8'($urandom);
    len  = $urandom_range(1, 6);
    for (int j = 0; j < len; j++) begin
      if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 65535) - 32768;
      else b = $urandom_range(0, 8192) - 4096;
      if ($urandom_range(0, 9) == 0) s = $urandom_range(0, 65535) - 32768;
      else s = b + $urandom_range(0, 12288);
      send_item(ACT_WRITE_BOTTOM, 8'(base + j), clamp_height(b));
      send_item(ACT_WRITE_SURFACE, 8'(base + j), clamp_height(s));
    end
    repeat ($urandom_range(1, 3)) send_item(ACT_RUN_STEP, 8'($urandom), 16'($urandom));
    repeat ($urandom_range(1, 4)) begin
      send_item(ACT_READ, 8'(base + $urandom_range(0, len + 1) - 1), 16'($urandom));
    end
  endtask

  initial begin
    int          phase_idle [4];
    logic [15:0] phase_flux [4];
    logic [15:0] phase_accel [4];
    int          target;
    bit          paused;
    phase_idle  = '{28, 64, 0, 0};
    phase_flux  = '{16'hffff, 16'h0000, 16'($urandom_range(1, 1023)), 16'($urandom)};
    phase_accel = '{16'hffff, 16'h0000, 16'($urandom_range(1, 1023)), 16'($urandom)};
    paused = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state, deep and dry columns, border and first and last interior columns.
    send_item(ACT_READ, 8'd0, 16'h0000);
    send_item(ACT_READ, 8'd255, 16'hffff);
    send_item(ACT_WRITE_BOTTOM, 8'd10, 16'h8000);
    send_item(ACT_WRITE_SURFACE, 8'd10, 16'h7fff);
    send_item(ACT_WRITE_BOTTOM, 8'd20, 16'h2000);
    send_item(ACT_WRITE_SURFACE, 8'd20, 16'h1000);
    send_item(ACT_WRITE_SURFACE, 8'd11, 16'h1000);
    send_item(ACT_WRITE_SURFACE, 8'd3, 16'h0800);
    send_item(ACT_WRITE_SURFACE, 8'd252, 16'h7fff);
    send_item(ACT_WRITE_SURFACE, 8'd0, 16'h8000);
    send_item(ACT_WRITE_BOTTOM, 8'd255, 16'h7fff);
    send_item(ACT_WRITE_SURFACE, 8'd255, 16'h5555);
    send_item(ACT_RUN_STEP, 8'haa, 16'haaaa);
    send_item(ACT_READ, 8'd10, 16'h5555);
    send_item(ACT_READ, 8'd9, 16'h0000);
    send_item(ACT_READ, 8'd3, 16'h0000);
    send_item(ACT_READ, 8'd252, 16'h0000);
    send_item(ACT_READ, 8'd253, 16'h0000);
    send_item(ACT_READ, 8'd0, 16'h0000);
    send_item(ACT_READ, 8'd20, 16'h0000);
    send_item(ACT_RUN_STEP, 8'h55, 16'h5555);
    send_item(ACT_READ, 8'd10, 16'h0000);
    send_item(ACT_READ, 8'd11, 16'h0000);
    send_item(ACT_READ, 8'd251, 16'h0000);

    for (int p = 0; p < 4; p++) begin
      settle();
      set_gains(phase_flux[p], phase_accel[p]);
      idle_pct = phase_idle[p];
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if (p == 0 && !paused && items_sent >= target - PHASE_ITEMS / 2) begin
          settle();
          paused = 1'b1;
        end
        if ($urandom_range(0, 99) < 70) begin
          profile_sequence();
        end else begin
          send_item(action_e'($urandom_range(0, 3)), 8'($urandom), 16'($urandom));
        end
      end
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    for (int n = 0; n < 4 * COLUMNS && pending != 0; n++) @(posedge clk_i);
    repeat (3 * COLUMNS + 8) @(posedge clk_i);

    $display("Sent %0d commands including %0d time steps; %0d column reads compared.",
             items_sent, steps_sent, reads_checked);
    $display("Gains covered the reset values, both extremes and two random settings.");
    if (pending != 0) $display("%0d column reads never returned a result.", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Run stopped by the time limit.");
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== shallow_water_surface_step_unit.f =====
+incdir+sv
sv/swss_pkg.sv
sv/swss_cell.sv
sv/swss_update.sv
sv/shallow_water_surface_step_unit.sv
test/surface_step_checker.sv
test/testbench.sv
